>>> rtl/distance_fog_pixel_blend_unit_defines.svh
// Assertion macros for the fog blend unit.
`ifndef DISTANCE_FOG_PIXEL_BLEND_UNIT_DEFINES_SVH
`define DISTANCE_FOG_PIXEL_BLEND_UNIT_DEFINES_SVH

`ifndef SYNTH
`define DFPB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fog blend assertion failed");
`define DFPB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fog blend assertion failed");
`else
`define DFPB_ASSERT_IMP(lbl, ante, cons)
`define DFPB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/dfpb_pkg.sv
package dfpb_pkg;

   localparam int NUM_CHAN   = 3;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = NUM_CHAN * CHAN_W;
   localparam int DIST_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int DENS_W     = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;

   localparam int D2_W   = 2 * DIST_W;
   localparam int X_W    = DENS_W + D2_W;
   localparam int DEN_W  = X_W + 1;
   localparam int REM_W  = DEN_W;
   localparam int QUO_W  = 17;
   localparam int DIV_STEPS = QUO_W;
   localparam int CG_W   = CHAN_W + GAIN_W;
   localparam int SRC_W  = CG_W + QUO_W;
   localparam int FOGT_W = CHAN_W + QUO_W;
   localparam int FOG_SHIFT   = 14;
   localparam int BLEND_SHIFT = 30;
   localparam int SUM_W  = SRC_W + 1;
   localparam int VAL_W  = SUM_W - BLEND_SHIFT;

   localparam logic [QUO_W-1:0]  FOG_ONE      = QUO_W'(65536);
   localparam logic [DEN_W-1:0]  DEN_ONE      = DEN_W'(64'd1 << 32);
   localparam logic [REM_W-1:0]  DIV_REM_INIT = REM_W'(64'd1 << 31);
   localparam logic [VAL_W-1:0]  CHAN_MAX     = VAL_W'(255);

   localparam logic [PIX_W-1:0]  FOG_COLOR_RST   = PIX_W'(24'h1A1B26);
   localparam logic [DENS_W-1:0] FOG_DENSITY_RST = DENS_W'(3277);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOG_COLOR   = 1'b0,
      CSR_FOG_DENSITY = 1'b1
   } csr_index_type;

   typedef logic [NUM_CHAN-1:0][CG_W-1:0]   chan_gain_type;
   typedef logic [NUM_CHAN-1:0][SRC_W-1:0]  chan_src_type;
   typedef logic [NUM_CHAN-1:0][FOGT_W-1:0] chan_fog_type;

endpackage

>>> rtl/distance_fog_pixel_blend_unit.sv
// A result is registered in stage 1, stage 2, the divider stages, mix and output.
// Throughput: one pixel per clock unless the output stalls; the 17-stage restoring
// divider for the fog factor, one quotient bit per stage, sets the pipeline depth.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous): clears all valid bits, loads fog color 0x1A1B26 and
// density 3277.
`include "distance_fog_pixel_blend_unit_defines.svh"

module distance_fog_pixel_blend_unit import dfpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_color,
   input  logic [DIST_W-1:0]     req_distance,
   input  logic [GAIN_W-1:0]     req_pulse_gain,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_fogged_color,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LAST = DIV_STEPS - 1;

   // configuration
   logic [PIX_W-1:0]  fog_color_ff,   fog_color_in;
   logic [DENS_W-1:0] fog_density_ff, fog_density_in;

   always_comb begin
      fog_color_in   = fog_color_ff;
      fog_density_in = fog_density_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FOG_COLOR:   fog_color_in   = csr_wdata[PIX_W-1:0];
            CSR_FOG_DENSITY: fog_density_in = csr_wdata[DENS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fog_color_ff   <= FOG_COLOR_RST;
         fog_density_ff <= FOG_DENSITY_RST;
      end else begin
         fog_color_ff   <= fog_color_in;
         fog_density_ff <= fog_density_in;
      end
   end

   // global advance: pipeline moves unless a finished result is held
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 1: squared distance, channel times gain
   logic               s1_vld_ff, s1_vld_in;
   logic [D2_W-1:0]    s1_d2_ff,  s1_d2_in;
   chan_gain_type      s1_cg_ff,  s1_cg_in;

   assign s1_vld_in = req_valid;
   assign s1_d2_in  = D2_W'(req_distance) * D2_W'(req_distance);

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         s1_cg_in[ch] = CG_W'(req_pixel_color[ch*CHAN_W +: CHAN_W]) * CG_W'(req_pulse_gain);
      end
   end

   // stage 2: denominator 2^32 + density * d2
   logic               s2_vld_ff, s2_vld_in;
   logic [DEN_W-1:0]   s2_den_ff, s2_den_in;
   chan_gain_type      s2_cg_ff,  s2_cg_in;
   logic [X_W-1:0]     s2_x;

   assign s2_x      = X_W'(fog_density_ff) * X_W'(s1_d2_ff);
   assign s2_vld_in = s1_vld_ff;
   assign s2_den_in = DEN_ONE + DEN_W'(s2_x);
   assign s2_cg_in  = s1_cg_ff;

   // divider: f = floor(2^48 / den), one quotient bit per stage
   logic               div_vld_ff [DIV_STEPS];
   logic               div_vld_in [DIV_STEPS];
   logic [REM_W-1:0]   div_p_ff   [DIV_STEPS];
   logic [REM_W-1:0]   div_p_in   [DIV_STEPS];
   logic [QUO_W-1:0]   div_q_ff   [DIV_STEPS];
   logic [QUO_W-1:0]   div_q_in   [DIV_STEPS];
   logic [DEN_W-1:0]   div_den_ff [DIV_STEPS];
   logic [DEN_W-1:0]   div_den_in [DIV_STEPS];
   chan_gain_type      div_cg_ff  [DIV_STEPS];
   chan_gain_type      div_cg_in  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic               vld_prev;
      logic [REM_W-1:0]   p_prev;
      logic [QUO_W-1:0]   q_prev;
      logic [DEN_W-1:0]   den_prev;
      chan_gain_type      cg_prev;
      logic [REM_W:0]     trial;
      logic               ge;

      if (k == 0) begin : g_first
         assign vld_prev = s2_vld_ff;
         assign p_prev   = DIV_REM_INIT;
         assign q_prev   = '0;
         assign den_prev = s2_den_ff;
         assign cg_prev  = s2_cg_ff;
      end else begin : g_next
         assign vld_prev = div_vld_ff[k-1];
         assign p_prev   = div_p_ff[k-1];
         assign q_prev   = div_q_ff[k-1];
         assign den_prev = div_den_ff[k-1];
         assign cg_prev  = div_cg_ff[k-1];
      end

      assign trial         = {p_prev, 1'b0};
      assign ge            = trial >= {1'b0, den_prev};
      assign div_vld_in[k] = vld_prev;
      assign div_p_in[k]   = ge ? REM_W'(trial - {1'b0, den_prev}) : trial[REM_W-1:0];
      assign div_q_in[k]   = {q_prev[QUO_W-2:0], ge};
      assign div_den_in[k] = den_prev;
      assign div_cg_in[k]  = cg_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k] <= div_vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_p_ff[k]   <= div_p_in[k];
            div_q_ff[k]   <= div_q_in[k];
            div_den_ff[k] <= div_den_in[k];
            div_cg_ff[k]  <= div_cg_in[k];
         end
      end
   end

   // mix stage: source and fog products
   logic               mix_vld_ff,  mix_vld_in;
   chan_src_type       mix_src_ff,  mix_src_in;
   chan_fog_type       mix_fogt_ff, mix_fogt_in;
   logic [QUO_W-1:0]   fog_f;
   logic [QUO_W-1:0]   fog_inv;

   assign fog_f      = (div_q_ff[LAST] > FOG_ONE) ? FOG_ONE : div_q_ff[LAST];
   assign fog_inv    = FOG_ONE - fog_f;
   assign mix_vld_in = div_vld_ff[LAST];

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         mix_src_in[ch]  = SRC_W'(div_cg_ff[LAST][ch]) * SRC_W'(fog_f);
         mix_fogt_in[ch] = FOGT_W'(fog_color_ff[ch*CHAN_W +: CHAN_W]) * FOGT_W'(fog_inv);
      end
   end

   // output stage: sum, truncate, saturate
   logic [PIX_W-1:0]   rsp_color_ff, rsp_color_in;

   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [VAL_W-1:0] val;
      rsp_color_in = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum = SUM_W'(mix_src_ff[ch]) + (SUM_W'(mix_fogt_ff[ch]) << FOG_SHIFT);
         val = sum[SUM_W-1:BLEND_SHIFT];
         rsp_color_in[ch*CHAN_W +: CHAN_W] = (val > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0]
                                                             : val[CHAN_W-1:0];
      end
   end

   assign rsp_valid_in = mix_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         mix_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         mix_vld_ff   <= mix_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d2_ff     <= s1_d2_in;
         s1_cg_ff     <= s1_cg_in;
         s2_den_ff    <= s2_den_in;
         s2_cg_ff     <= s2_cg_in;
         mix_src_ff   <= mix_src_in;
         mix_fogt_ff  <= mix_fogt_in;
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fogged_color = rsp_color_ff;

   `DFPB_ASSERT_IMP(a_div_rem_below_den, div_vld_ff[LAST], div_p_ff[LAST] < div_den_ff[LAST])
   `DFPB_ASSERT_IMP(a_fog_factor_max, div_vld_ff[LAST], div_q_ff[LAST] <= FOG_ONE)
   `DFPB_ASSERT_IMP(a_no_fog_full_factor, div_vld_ff[LAST] && div_den_ff[LAST] == DEN_ONE, div_q_ff[LAST] == FOG_ONE)
   `DFPB_ASSERT_NEXT(a_mix_reaches_out, adv && mix_vld_ff, rsp_valid_ff)

endmodule
